// ===== sv/scef_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scef_pkg
// Shared constants and register codes for the soft-crop edge feather block.
// ----------------------------------------------------------------------------
package scef_pkg;

    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;

    localparam int NUM_EDGES    = 4;
    localparam int NUM_CHANNELS = 4;

    // edges in the order their ramps are applied
    localparam logic [1:0] EDGE_TOP    = 2'd0;
    localparam logic [1:0] EDGE_BOTTOM = 2'd1;
    localparam logic [1:0] EDGE_LEFT   = 2'd2;
    localparam logic [1:0] EDGE_RIGHT  = 2'd3;

    // channel order in the data words
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_ALPHA = 2'd3;

    typedef enum logic [2:0] {
        REG_FRAME_RIGHT  = 3'd0,
        REG_FRAME_BOTTOM = 3'd1,
        REG_SOFT_TOP     = 3'd2,
        REG_SOFT_LEFT    = 3'd3,
        REG_SOFT_BOTTOM  = 3'd4,
        REG_SOFT_RIGHT   = 3'd5,
        REG_ALPHA_MODE   = 3'd6
    } cfg_reg_t;

endpackage

// ===== sv/soft_crop_edge_feather.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soft_crop_edge_feather
// Per-pixel soft-crop feathering of RGBA pixels near the frame edges.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one pixel request per beat: column, row and four channels.
//   m_* returns the feathered pixel, one result per request, in order.
//   The APB port sets frame edges, the four feather widths and alpha-only
//   mode; write it only while no pixel is in flight.
// Throughput: one pixel per clock while the output is not stalled. Each edge
//   ratio runs through a pipelined restoring divider that resolves one
//   quotient bit per stage. Pipeline: one distance stage, FRAC_BITS divider
//   stages, four product stages and the output register, from the input
//   handshake to m_tvalid.
// Reset: aresetn low clears the configuration registers to zero, which
//   disables every edge, and clears the valid flags, emptying the pipeline.
// Stall: when m_tready is low the output register holds its pixel and the
//   skid stage takes the next result that arrives; s_tready then drops and
//   the pipeline freezes until the skid stage drains. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module soft_crop_edge_feather
    import scef_pkg::*;
#(
    parameter int COORD_BITS   = 13,
    parameter int CHANNEL_BITS = 16,
    parameter int FRAC_BITS    = 16,
    localparam int S_TDATA_BITS =
        ((2 * COORD_BITS + NUM_CHANNELS * CHANNEL_BITS + 7) / 8) * 8,
    localparam int M_TDATA_BITS = ((NUM_CHANNELS * CHANNEL_BITS + 7) / 8) * 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // pixel_x, pixel_y, in_red, in_green, in_blue, in_alpha, zero pad
    input  logic [S_TDATA_BITS-1:0]  s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // out_red, out_green, out_blue, out_alpha, zero pad
    output logic [M_TDATA_BITS-1:0]  m_tdata,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    typedef logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] pixel_t;

    logic [COORD_BITS-1:0]                frame_right;
    logic [COORD_BITS-1:0]                frame_bottom;
    logic [NUM_EDGES-1:0][COORD_BITS-1:0] soft_width;
    logic                                 alpha_mode;

    logic                                 pipe_en;
    logic [COORD_BITS-1:0]                pixel_x;
    logic [COORD_BITS-1:0]                pixel_y;
    pixel_t                               pixel_in;
    logic [NUM_EDGES-1:0][COORD_BITS-1:0] dist_next;
    logic [NUM_EDGES-1:0]                 active_next;

    logic                                 s0_valid_reg;
    logic [NUM_EDGES-1:0][COORD_BITS-1:0] s0_dist_reg;
    logic [NUM_EDGES-1:0]                 s0_active_reg;
    pixel_t                               s0_pixel_reg;

    logic                                 dly_valid_reg [FRAC_BITS];
    pixel_t                               dly_pixel_reg [FRAC_BITS];

    logic [NUM_EDGES-1:0][FRAC_BITS:0]    ratio;
    logic                                 sc_valid;
    pixel_t                               sc_pixel;

    logic                                 out_valid_reg;
    pixel_t                               out_pixel_reg;
    logic                                 skid_valid_reg;
    pixel_t                               skid_pixel_reg;

    scef_cfg_regs #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .frame_right  (frame_right),
        .frame_bottom (frame_bottom),
        .soft_width   (soft_width),
        .alpha_mode   (alpha_mode)
    );

    // the pipeline moves as a whole; the skid stage absorbs one output stall
    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;

    assign pixel_x = s_tdata[COORD_BITS-1:0];
    assign pixel_y = s_tdata[2*COORD_BITS-1:COORD_BITS];

    always_comb begin
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            pixel_in[k] = s_tdata[2*COORD_BITS + k*CHANNEL_BITS +: CHANNEL_BITS];
        end
        dist_next[EDGE_TOP]    = pixel_y;
        dist_next[EDGE_BOTTOM] = (pixel_y > frame_bottom) ? '0 : frame_bottom - pixel_y;
        dist_next[EDGE_LEFT]   = pixel_x;
        dist_next[EDGE_RIGHT]  = (pixel_x > frame_right) ? '0 : frame_right - pixel_x;
        for (int e = 0; e < NUM_EDGES; e++) begin
            active_next[e] = (soft_width[e] != '0) && (dist_next[e] < soft_width[e]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            for (int j = 0; j < FRAC_BITS; j++) begin
                dly_valid_reg[j] <= 1'b0;
            end
        end else if (pipe_en) begin
            s0_valid_reg     <= s_tvalid;
            dly_valid_reg[0] <= s0_valid_reg;
            for (int j = 1; j < FRAC_BITS; j++) begin
                dly_valid_reg[j] <= dly_valid_reg[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s0_dist_reg      <= dist_next;
            s0_active_reg    <= active_next;
            s0_pixel_reg     <= pixel_in;
            dly_pixel_reg[0] <= s0_pixel_reg;
            for (int j = 1; j < FRAC_BITS; j++) begin
                dly_pixel_reg[j] <= dly_pixel_reg[j-1];
            end
        end
    end

    for (genvar e = 0; e < NUM_EDGES; e++) begin : g_edge
        scef_ramp_div #(
            .COORD_BITS (COORD_BITS),
            .FRAC_BITS  (FRAC_BITS)
        ) u_ramp_div (
            .aclk      (aclk),
            .pipe_en   (pipe_en),
            .dist_in   (s0_dist_reg[e]),
            .width_in  (soft_width[e]),
            .active_in (s0_active_reg[e]),
            .ratio_out (ratio[e])
        );
    end

    scef_scale #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pipe_en    (pipe_en),
        .in_valid   (dly_valid_reg[FRAC_BITS-1]),
        .ratio      (ratio),
        .chan_in    (dly_pixel_reg[FRAC_BITS-1]),
        .alpha_mode (alpha_mode),
        .out_valid  (sc_valid),
        .chan_out   (sc_pixel)
    );

    // output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                out_pixel_reg  <= skid_pixel_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= sc_valid;
                out_pixel_reg  <= sc_pixel;
            end
        end else if (sc_valid && pipe_en) begin
            skid_valid_reg <= 1'b1;
            skid_pixel_reg <= sc_pixel;
        end
    end

    always_comb begin
        m_tdata = '0;
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            m_tdata[k*CHANNEL_BITS +: CHANNEL_BITS] = out_pixel_reg[k];
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== sv/scef_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scef_cfg_regs
// APB register file: frame edges, feather widths and alpha-only mode.
// ----------------------------------------------------------------------------
module scef_cfg_regs
    import scef_pkg::*;
#(
    parameter int COORD_BITS = 13
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [APB_ADDR_BITS-1:0]               paddr,
    input  logic [APB_DATA_BITS-1:0]               pwdata,
    output logic [APB_DATA_BITS-1:0]               prdata,
    output logic                                   pready,
    output logic [COORD_BITS-1:0]                  frame_right,
    output logic [COORD_BITS-1:0]                  frame_bottom,
    output logic [NUM_EDGES-1:0][COORD_BITS-1:0]   soft_width,
    output logic                                   alpha_mode
);

    logic [COORD_BITS-1:0]                frame_right_reg;
    logic [COORD_BITS-1:0]                frame_bottom_reg;
    logic [NUM_EDGES-1:0][COORD_BITS-1:0] soft_width_reg;
    logic                                 alpha_mode_reg;
    cfg_reg_t                             reg_sel;
    logic                                 wr_en;

    assign pready  = 1'b1;
    assign reg_sel = cfg_reg_t'(paddr[APB_ADDR_BITS-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_right_reg  <= '0;
            frame_bottom_reg <= '0;
            soft_width_reg   <= '0;
            alpha_mode_reg   <= 1'b0;
        end else if (wr_en) begin
            case (reg_sel)
                REG_FRAME_RIGHT:  frame_right_reg  <= pwdata[COORD_BITS-1:0];
                REG_FRAME_BOTTOM: frame_bottom_reg <= pwdata[COORD_BITS-1:0];
                REG_SOFT_TOP:     soft_width_reg[EDGE_TOP]    <= pwdata[COORD_BITS-1:0];
                REG_SOFT_LEFT:    soft_width_reg[EDGE_LEFT]   <= pwdata[COORD_BITS-1:0];
                REG_SOFT_BOTTOM:  soft_width_reg[EDGE_BOTTOM] <= pwdata[COORD_BITS-1:0];
                REG_SOFT_RIGHT:   soft_width_reg[EDGE_RIGHT]  <= pwdata[COORD_BITS-1:0];
                REG_ALPHA_MODE:   alpha_mode_reg   <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_FRAME_RIGHT:  prdata = APB_DATA_BITS'(frame_right_reg);
            REG_FRAME_BOTTOM: prdata = APB_DATA_BITS'(frame_bottom_reg);
            REG_SOFT_TOP:     prdata = APB_DATA_BITS'(soft_width_reg[EDGE_TOP]);
            REG_SOFT_LEFT:    prdata = APB_DATA_BITS'(soft_width_reg[EDGE_LEFT]);
            REG_SOFT_BOTTOM:  prdata = APB_DATA_BITS'(soft_width_reg[EDGE_BOTTOM]);
            REG_SOFT_RIGHT:   prdata = APB_DATA_BITS'(soft_width_reg[EDGE_RIGHT]);
            REG_ALPHA_MODE:   prdata = APB_DATA_BITS'(alpha_mode_reg);
            default:          prdata = '0;
        endcase
    end

    assign frame_right  = frame_right_reg;
    assign frame_bottom = frame_bottom_reg;
    assign soft_width   = soft_width_reg;
    assign alpha_mode   = alpha_mode_reg;

endmodule

// ===== sv/scef_ramp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scef_ramp_div
// Pipelined restoring divider: ratio = floor(dist * 2^FRAC_BITS / width),
// one quotient bit per stage. Inactive edges yield 1.0.
// ----------------------------------------------------------------------------
module scef_ramp_div
    import scef_pkg::*;
#(
    parameter int COORD_BITS = 13,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  pipe_en,
    input  logic [COORD_BITS-1:0] dist_in,
    input  logic [COORD_BITS-1:0] width_in,
    input  logic                  active_in,
    output logic [FRAC_BITS:0]    ratio_out
);

    logic [COORD_BITS-1:0] rem_reg  [FRAC_BITS];
    logic [FRAC_BITS-1:0]  quo_reg  [FRAC_BITS];
    logic                  act_reg  [FRAC_BITS];
    logic [COORD_BITS-1:0] rem_in   [FRAC_BITS];
    logic [FRAC_BITS-1:0]  quo_in   [FRAC_BITS];
    logic                  act_in   [FRAC_BITS];
    logic [COORD_BITS:0]   shifted  [FRAC_BITS];
    logic                  take     [FRAC_BITS];
    logic [COORD_BITS-1:0] rem_next [FRAC_BITS];
    logic [FRAC_BITS-1:0]  quo_next [FRAC_BITS];
    logic [COORD_BITS:0]   width_ext;

    assign width_ext = {1'b0, width_in};

    always_comb begin
        rem_in[0] = dist_in;
        quo_in[0] = '0;
        act_in[0] = active_in;
        for (int j = 1; j < FRAC_BITS; j++) begin
            rem_in[j] = rem_reg[j-1];
            quo_in[j] = quo_reg[j-1];
            act_in[j] = act_reg[j-1];
        end
        for (int j = 0; j < FRAC_BITS; j++) begin
            shifted[j] = {rem_in[j], 1'b0};
            take[j]    = (shifted[j] >= width_ext);
            // remainder stays below the width, so the top bit drops
            rem_next[j] = take[j] ? COORD_BITS'(shifted[j] - width_ext)
                                  : shifted[j][COORD_BITS-1:0];
            quo_next[j] = {quo_in[j][FRAC_BITS-2:0], take[j]};
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int j = 0; j < FRAC_BITS; j++) begin
                rem_reg[j] <= rem_next[j];
                quo_reg[j] <= quo_next[j];
                act_reg[j] <= act_in[j];
            end
        end
    end

    assign ratio_out = act_reg[FRAC_BITS-1] ? {1'b0, quo_reg[FRAC_BITS-1]}
                                            : {1'b1, {FRAC_BITS{1'b0}}};

endmodule

// ===== sv/scef_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scef_scale
// Four-stage product chain: combine the edge ratios into one factor, then
// scale alpha or all channels by it.
// ----------------------------------------------------------------------------
module scef_scale
    import scef_pkg::*;
#(
    parameter int CHANNEL_BITS = 16,
    parameter int FRAC_BITS    = 16
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     pipe_en,
    input  logic                                     in_valid,
    input  logic [NUM_EDGES-1:0][FRAC_BITS:0]        ratio,
    input  logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] chan_in,
    input  logic                                     alpha_mode,
    output logic                                     out_valid,
    output logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] chan_out
);

    localparam int PROD_BITS   = 2 * FRAC_BITS + 2;
    localparam int SCALED_BITS = CHANNEL_BITS + FRAC_BITS + 1;

    logic                                      valid_a_reg;
    logic                                      valid_b_reg;
    logic                                      valid_c_reg;
    logic                                      valid_d_reg;
    logic [PROD_BITS-1:0]                      prod_a_reg;
    logic [PROD_BITS-1:0]                      prod_b_reg;
    logic [PROD_BITS-1:0]                      prod_c_reg;
    logic [FRAC_BITS:0]                        ratio_left_a_reg;
    logic [FRAC_BITS:0]                        ratio_right_a_reg;
    logic [FRAC_BITS:0]                        ratio_right_b_reg;
    logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] chan_a_reg;
    logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] chan_b_reg;
    logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] chan_c_reg;
    logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] chan_d_reg;
    logic [NUM_CHANNELS-1:0][SCALED_BITS-1:0]  scaled_d_reg;
    logic [FRAC_BITS:0]                        factor_b;
    logic [FRAC_BITS:0]                        factor_c;
    logic [FRAC_BITS:0]                        factor_d;

    // every partial factor is at most 1.0
    assign factor_b = prod_a_reg[2*FRAC_BITS:FRAC_BITS];
    assign factor_c = prod_b_reg[2*FRAC_BITS:FRAC_BITS];
    assign factor_d = prod_c_reg[2*FRAC_BITS:FRAC_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
        end else if (pipe_en) begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
            valid_d_reg <= valid_c_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            prod_a_reg        <= PROD_BITS'(ratio[EDGE_TOP]) * PROD_BITS'(ratio[EDGE_BOTTOM]);
            ratio_left_a_reg  <= ratio[EDGE_LEFT];
            ratio_right_a_reg <= ratio[EDGE_RIGHT];
            chan_a_reg        <= chan_in;

            prod_b_reg        <= PROD_BITS'(factor_b) * PROD_BITS'(ratio_left_a_reg);
            ratio_right_b_reg <= ratio_right_a_reg;
            chan_b_reg        <= chan_a_reg;

            prod_c_reg        <= PROD_BITS'(factor_c) * PROD_BITS'(ratio_right_b_reg);
            chan_c_reg        <= chan_b_reg;

            for (int k = 0; k < NUM_CHANNELS; k++) begin
                scaled_d_reg[k] <= SCALED_BITS'(chan_c_reg[k]) * SCALED_BITS'(factor_d);
            end
            chan_d_reg        <= chan_c_reg;
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            if (alpha_mode && (k != int'(CH_ALPHA))) begin
                chan_out[k] = chan_d_reg[k];
            end else begin
                chan_out[k] = scaled_d_reg[k][FRAC_BITS +: CHANNEL_BITS];
            end
        end
    end

    assign out_valid = valid_d_reg;

endmodule

// ===== sv/scef_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scef_checker
// Port-level checks on the stream handshakes of the feather block.
// ----------------------------------------------------------------------------
module scef_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready
);

    // hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // drop results on reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // backpressure only behind a held result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input blocked with empty output");

    // input blocks only after the output stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("input blocked without output stall");

endmodule

bind soft_crop_edge_feather scef_checker u_scef_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
